@@ design/iak_pkg.sv @@
package iak_pkg;

    localparam int TIME_WIDTH = 24;
    localparam int CMD_WIDTH = 3;
    localparam int STATE_WIDTH = 4;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [TIME_WIDTH-1:0] DOT_TIME_RESET = TIME_WIDTH'(100000);
    localparam logic [TIME_WIDTH-1:0] DASH_TIME_RESET = TIME_WIDTH'(300000);
    localparam logic [TIME_WIDTH-1:0] GAP_TIME_RESET = TIME_WIDTH'(100000);

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_BOTH  = 3'd0,
        CMD_DOT   = 3'd1,
        CMD_DASH  = 3'd2,
        CMD_DONE  = 3'd3,
        CMD_RESET = 3'd4
    } cmd_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MODE_B    = 2'd0,
        REG_DOT_TIME  = 2'd1,
        REG_DASH_TIME = 2'd2,
        REG_GAP_TIME  = 2'd3
    } reg_index_t;

    typedef enum logic [STATE_WIDTH-1:0] {
        ST_IDLE         = 4'd0,
        ST_IN_DOT_A     = 4'd1,
        ST_IN_DASH_A    = 4'd2,
        ST_AFTER_DOT_A  = 4'd3,
        ST_AFTER_DASH_A = 4'd4,
        ST_IN_DOT_B     = 4'd5,
        ST_IN_DASH_B    = 4'd6,
        ST_AFTER_DOT_B  = 4'd7,
        ST_AFTER_DASH_B = 4'd8
    } keyer_state_t;

    typedef struct packed {
        logic                  mode_b;
        logic [TIME_WIDTH-1:0] dot_time;
        logic [TIME_WIDTH-1:0] dash_time;
        logic [TIME_WIDTH-1:0] gap_time;
    } cfg_t;

    typedef struct packed {
        keyer_state_t st;
        logic         dot_held;
        logic         dash_held;
        logic         dot_latched;
        logic         dash_latched;
        logic         squeeze_latched;
    } keyer_t;

    typedef struct packed {
        logic [CMD_WIDTH-1:0] command;
        logic                 dot_pressed;
        logic                 dash_pressed;
    } item_t;

    typedef struct packed {
        logic                   tone_valid;
        logic                   key_closed;
        logic [TIME_WIDTH-1:0]  tone_length;
        logic                   busy_res;
        logic [STATE_WIDTH-1:0] state_code;
        logic                   dot_latch_out;
        logic                   dash_latch_out;
    } result_t;

endpackage

@@ design/iambic_keyer_mode_a_b.sv @@
// An accepted item waits in the input register; its result then loads the m_ port
// result register. Throughput: one item per cycle unless m_ready stalls; the keyer
// state loads in the same cycle as the result, so the next item sees it without a bubble.
// Reset: aresetn, synchronous and active low, clears the keyer state and latches
// and returns the four registers to mode A, dot 100000, dash 300000, gap 100000.
module iambic_keyer_mode_a_b
    import iak_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CMD_WIDTH-1:0]       s_command,
    input  logic                       s_dot_pressed,
    input  logic                       s_dash_pressed,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_tone_valid,
    output logic                       m_key_closed,
    output logic [TIME_WIDTH-1:0]      m_tone_length,
    output logic                       m_busy_res,
    output logic [STATE_WIDTH-1:0]     m_state_code,
    output logic                       m_dot_latch_out,
    output logic                       m_dash_latch_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [TIME_WIDTH-1:0]      cfg_data
);

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    keyer_t  keyer_reg;
    keyer_t  keyer_next;
    result_t res_next;
    result_t out_reg;
    logic    out_valid_reg;
    logic    step_fire;

    iak_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iak_step u_step (
        .item       (in_reg),
        .keyer      (keyer_reg),
        .cfg        (cfg),
        .keyer_next (keyer_next),
        .res        (res_next)
    );

    assign step_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            keyer_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (step_fire) begin
                out_valid_reg <= 1'b1;
                keyer_reg     <= keyer_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.command      <= s_command;
            in_reg.dot_pressed  <= s_dot_pressed;
            in_reg.dash_pressed <= s_dash_pressed;
        end
        if (step_fire) begin
            out_reg <= res_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_tone_valid     = out_reg.tone_valid;
    assign m_key_closed     = out_reg.key_closed;
    assign m_tone_length    = out_reg.tone_length;
    assign m_busy_res       = out_reg.busy_res;
    assign m_state_code     = out_reg.state_code;
    assign m_dot_latch_out  = out_reg.dot_latch_out;
    assign m_dash_latch_out = out_reg.dash_latch_out;

`ifndef SYNTHESIS
    // A closed key always comes with a busy keyer and a valid tone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_key_closed |-> m_busy_res && m_tone_valid)
        else $error("key closed while keyer not in an element");

    // A gap tone always leaves the keyer in one of the after-element states.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tone_valid && !m_key_closed |->
            (m_state_code == ST_AFTER_DOT_A) || (m_state_code == ST_AFTER_DASH_A) ||
            (m_state_code == ST_AFTER_DOT_B) || (m_state_code == ST_AFTER_DASH_B))
        else $error("gap tone outside an after-element state");

    // Each processed item must reach the result register on the next edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |=> m_valid && (m_state_code == $past(keyer_next.st)))
        else $error("processed item did not reach the result register");

    // When no item waits, the result state code and dot latch match the stored keyer state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !in_valid_reg |-> (m_state_code == keyer_reg.st) &&
            (m_dot_latch_out == keyer_reg.dot_latched))
        else $error("result status disagrees with the keyer state");
`endif

endmodule

@@ design/iak_cfg_regs.sv @@
module iak_cfg_regs
    import iak_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [TIME_WIDTH-1:0]      cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_b    <= 1'b0;
            cfg_reg.dot_time  <= DOT_TIME_RESET;
            cfg_reg.dash_time <= DASH_TIME_RESET;
            cfg_reg.gap_time  <= GAP_TIME_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE_B:    cfg_reg.mode_b    <= cfg_data[0];
                REG_DOT_TIME:  cfg_reg.dot_time  <= cfg_data;
                REG_DASH_TIME: cfg_reg.dash_time <= cfg_data;
                REG_GAP_TIME:  cfg_reg.gap_time  <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ design/iak_step.sv @@
module iak_step
    import iak_pkg::*;
(
    input  item_t   item,
    input  keyer_t  keyer,
    input  cfg_t    cfg,
    output keyer_t  keyer_next,
    output result_t res
);

    typedef struct packed {
        keyer_t                k;
        logic                  tone;
        logic                  closed;
        logic [TIME_WIDTH-1:0] length;
    } adv_t;

    function automatic adv_t advance(keyer_t k, cfg_t c);
        adv_t a;
        a        = '0;
        a.k      = k;
        unique case (k.st)
            ST_IN_DOT_A, ST_IN_DOT_B, ST_IN_DASH_A, ST_IN_DASH_B: begin
                a.tone   = 1'b1;
                a.length = c.gap_time;
                unique case (k.st)
                    ST_IN_DOT_A: a.k.st = ST_AFTER_DOT_A;
                    ST_IN_DOT_B: a.k.st = ST_AFTER_DOT_B;
                    ST_IN_DASH_A: a.k.st = ST_AFTER_DASH_A;
                    default: a.k.st = ST_AFTER_DASH_B;
                endcase
            end
            ST_AFTER_DOT_A, ST_AFTER_DOT_B: begin
                if (!k.dot_held) begin
                    a.k.dot_latched = 1'b0;
                end
                if (k.st == ST_AFTER_DOT_B) begin
                    a.tone   = 1'b1;
                    a.closed = 1'b1;
                    a.length = c.dash_time;
                    a.k.st   = ST_IN_DASH_A;
                end else if (a.k.dash_latched) begin
                    a.tone   = 1'b1;
                    a.closed = 1'b1;
                    a.length = c.dash_time;
                    if (k.squeeze_latched) begin
                        a.k.squeeze_latched = 1'b0;
                        a.k.st = ST_IN_DASH_B;
                    end else begin
                        a.k.st = ST_IN_DASH_A;
                    end
                end else if (a.k.dot_latched) begin
                    a.tone   = 1'b1;
                    a.closed = 1'b1;
                    a.length = c.dot_time;
                    a.k.st   = ST_IN_DOT_A;
                end else begin
                    a.k.st = ST_IDLE;
                end
            end
            ST_AFTER_DASH_A, ST_AFTER_DASH_B: begin
                if (!k.dash_held) begin
                    a.k.dash_latched = 1'b0;
                end
                if (k.st == ST_AFTER_DASH_B) begin
                    a.tone   = 1'b1;
                    a.closed = 1'b1;
                    a.length = c.dot_time;
                    a.k.st   = ST_IN_DOT_A;
                end else if (a.k.dot_latched) begin
                    a.tone   = 1'b1;
                    a.closed = 1'b1;
                    a.length = c.dot_time;
                    if (k.squeeze_latched) begin
                        a.k.squeeze_latched = 1'b0;
                        a.k.st = ST_IN_DOT_B;
                    end else begin
                        a.k.st = ST_IN_DOT_A;
                    end
                end else if (a.k.dash_latched) begin
                    a.tone   = 1'b1;
                    a.closed = 1'b1;
                    a.length = c.dash_time;
                    a.k.st   = ST_IN_DASH_A;
                end else begin
                    a.k.st = ST_IDLE;
                end
            end
            default: a.k.st = ST_IDLE;
        endcase
        return a;
    endfunction

    logic   dot_lvl;
    logic   dash_lvl;
    logic   is_paddle;
    keyer_t pk;
    adv_t   adv;
    adv_t   fin;

    always_comb begin
        dot_lvl   = keyer.dot_held;
        dash_lvl  = keyer.dash_held;
        is_paddle = 1'b0;
        unique case (item.command)
            CMD_BOTH: begin
                is_paddle = 1'b1;
                dot_lvl   = item.dot_pressed;
                dash_lvl  = item.dash_pressed;
            end
            CMD_DOT: begin
                is_paddle = 1'b1;
                dot_lvl   = item.dot_pressed;
            end
            CMD_DASH: begin
                is_paddle = 1'b1;
                dash_lvl  = item.dash_pressed;
            end
            default: ;
        endcase

        pk = keyer;
        pk.dot_held  = dot_lvl;
        pk.dash_held = dash_lvl;
        if (dot_lvl) begin
            pk.dot_latched = 1'b1;
        end
        if (dash_lvl) begin
            pk.dash_latched = 1'b1;
        end
        if (cfg.mode_b && dot_lvl && dash_lvl) begin
            pk.squeeze_latched = 1'b1;
        end
        if ((keyer.st == ST_IDLE) || (keyer.st > ST_AFTER_DASH_B)) begin
            if (dot_lvl) begin
                pk.st = pk.squeeze_latched ? ST_AFTER_DASH_B : ST_AFTER_DASH_A;
            end else if (dash_lvl) begin
                pk.st = pk.squeeze_latched ? ST_AFTER_DOT_B : ST_AFTER_DOT_A;
            end else begin
                pk.st = ST_IDLE;
            end
        end

        adv = advance(is_paddle ? pk : keyer, cfg);

        fin   = '0;
        fin.k = keyer;
        unique case (item.command)
            CMD_BOTH, CMD_DOT, CMD_DASH: begin
                if ((keyer.st == ST_IDLE) || (keyer.st > ST_AFTER_DASH_B)) begin
                    fin = (pk.st == ST_IDLE) ? adv_t'{k: pk, default: '0} : adv;
                end else begin
                    fin.k = pk;
                end
            end
            CMD_DONE:  fin = adv;
            CMD_RESET: fin.k = '0;
            default: ;
        endcase
        if (fin.k.st > ST_AFTER_DASH_B) begin
            fin.k.st = ST_IDLE;
        end

        keyer_next         = fin.k;
        res.tone_valid     = fin.tone;
        res.key_closed     = fin.tone & fin.closed;
        res.tone_length    = fin.tone ? fin.length : '0;
        res.busy_res       = (fin.k.st != ST_IDLE);
        res.state_code     = fin.k.st;
        res.dot_latch_out  = fin.k.dot_latched;
        res.dash_latch_out = fin.k.dash_latched;
    end

endmodule

@@ test/tb_iambic_keyer_mode_a_b.sv @@
`timescale 1ns / 1ps

module tb_iambic_keyer_mode_a_b;
    import iak_pkg::*;

    localparam logic [CMD_WIDTH-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_WIDTH-1:0] CMD_SPARE_HI = 3'd7;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
    localparam int N_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int STALL_LIMIT = 1000;
    localparam int N_SCRIPT = 32;

    typedef struct {
        bit                    is_cfg;
        reg_index_t            idx;
        logic [TIME_WIDTH-1:0] data;
        logic [CMD_WIDTH-1:0]  cmd;
        logic                  dot;
        logic                  dash;
        bit                    typed;
        result_t               want;
    } script_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [CMD_WIDTH-1:0]       s_command;
    logic                       s_dot_pressed;
    logic                       s_dash_pressed;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_tone_valid;
    logic                       m_key_closed;
    logic [TIME_WIDTH-1:0]      m_tone_length;
    logic                       m_busy_res;
    logic [STATE_WIDTH-1:0]     m_state_code;
    logic                       m_dot_latch_out;
    logic                       m_dash_latch_out;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [TIME_WIDTH-1:0]      cfg_data;

    // Keyer state and registers as the predictor sees them.
    keyer_state_t          kst;
    bit                    held_dot, held_dash;
    bit                    lat_dot, lat_dash, lat_sq;
    bit                    mode_b_sel;
    logic [TIME_WIDTH-1:0] len_dot, len_dash, len_gap;
    result_t               step_res;

    result_t pending_tones[$];
    bit      idle_on = 1'b1;
    int      errors = 0;
    int      n_items = 0;
    int      n_ignored = 0;
    int      n_tones = 0;
    int      n_squeeze = 0;
    int      n_writes = 0;
    int      quiet_cycles = 0;

    script_row_t script [N_SCRIPT] = '{
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b1, '0},
        '{1'b0, REG_MODE_B, '0, CMD_BOTH, 1'b0, 1'b0, 1'b1, '0},
        '{1'b0, REG_MODE_B, '0, CMD_SPARE_LO, 1'b1, 1'b1, 1'b1, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DOT, 1'b1, 1'b0, 1'b1,
          '{1'b1, 1'b1, DOT_TIME_RESET, 1'b1, ST_IN_DOT_A, 1'b1, 1'b0}},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b1,
          '{1'b1, 1'b0, GAP_TIME_RESET, 1'b1, ST_AFTER_DOT_A, 1'b1, 1'b0}},
        '{1'b0, REG_MODE_B, '0, CMD_DOT, 1'b0, 1'b0, 1'b1,
          '{1'b0, 1'b0, '0, 1'b1, ST_AFTER_DOT_A, 1'b1, 1'b0}},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b1, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DASH, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_BOTH, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_BOTH, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DOT, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_RESET, 1'b1, 1'b1, 1'b1, '0},
        '{1'b0, REG_MODE_B, '0, CMD_SPARE_HI, 1'b1, 1'b0, 1'b1, '0},
        '{1'b1, REG_MODE_B, 24'd1, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_BOTH, 1'b1, 1'b1, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_BOTH, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, REG_DOT_TIME, 24'd1, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, REG_DASH_TIME, TIME_MAX, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b1, REG_GAP_TIME, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DASH, 1'b0, 1'b1, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DASH, 1'b0, 1'b0, 1'b0, '0},
        '{1'b0, REG_MODE_B, '0, CMD_DONE, 1'b0, 1'b0, 1'b0, '0}
    };

    iambic_keyer_mode_a_b uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_dot_pressed    (s_dot_pressed),
        .s_dash_pressed   (s_dash_pressed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tone_valid     (m_tone_valid),
        .m_key_closed     (m_key_closed),
        .m_tone_length    (m_tone_length),
        .m_busy_res       (m_busy_res),
        .m_state_code     (m_state_code),
        .m_dot_latch_out  (m_dot_latch_out),
        .m_dash_latch_out (m_dash_latch_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function void sound(input bit closed, input logic [TIME_WIDTH-1:0] len);
        step_res.tone_valid = 1'b1;
        step_res.key_closed = closed;
        step_res.tone_length = len;
    endfunction

    function void keyer_advance();
        case (kst)
            ST_IN_DOT_A: begin
                sound(1'b0, len_gap);
                kst = ST_AFTER_DOT_A;
            end
            ST_IN_DOT_B: begin
                sound(1'b0, len_gap);
                kst = ST_AFTER_DOT_B;
            end
            ST_IN_DASH_A: begin
                sound(1'b0, len_gap);
                kst = ST_AFTER_DASH_A;
            end
            ST_IN_DASH_B: begin
                sound(1'b0, len_gap);
                kst = ST_AFTER_DASH_B;
            end
            ST_AFTER_DOT_A, ST_AFTER_DOT_B: begin
                if (!held_dot) lat_dot = 1'b0;
                if (kst == ST_AFTER_DOT_B) begin
                    sound(1'b1, len_dash);
                    kst = ST_IN_DASH_A;
                end else if (lat_dash) begin
                    sound(1'b1, len_dash);
                    if (lat_sq) begin
                        lat_sq = 1'b0;
                        kst = ST_IN_DASH_B;
                    end else begin
                        kst = ST_IN_DASH_A;
                    end
                end else if (lat_dot) begin
                    sound(1'b1, len_dot);
                    kst = ST_IN_DOT_A;
                end else begin
                    kst = ST_IDLE;
                end
            end
            ST_AFTER_DASH_A, ST_AFTER_DASH_B: begin
                if (!held_dash) lat_dash = 1'b0;
                if (kst == ST_AFTER_DASH_B) begin
                    sound(1'b1, len_dot);
                    kst = ST_IN_DOT_A;
                end else if (lat_dot) begin
                    sound(1'b1, len_dot);
                    if (lat_sq) begin
                        lat_sq = 1'b0;
                        kst = ST_IN_DOT_B;
                    end else begin
                        kst = ST_IN_DOT_A;
                    end
                end else if (lat_dash) begin
                    sound(1'b1, len_dash);
                    kst = ST_IN_DASH_A;
                end else begin
                    kst = ST_IDLE;
                end
            end
            default: kst = ST_IDLE;
        endcase
    endfunction

    function void keyer_paddles(input bit dot, input bit dash);
        held_dot = dot;
        held_dash = dash;
        if (dot) lat_dot = 1'b1;
        if (dash) lat_dash = 1'b1;
        if (mode_b_sel && dot && dash) lat_sq = 1'b1;
        if (kst == ST_IDLE) begin
            if (held_dot) begin
                kst = lat_sq ? ST_AFTER_DASH_B : ST_AFTER_DASH_A;
                keyer_advance();
            end else if (held_dash) begin
                kst = lat_sq ? ST_AFTER_DOT_B : ST_AFTER_DOT_A;
                keyer_advance();
            end
        end
    endfunction

    function result_t keyer_step(input logic [CMD_WIDTH-1:0] cmd, input bit dot,
                                 input bit dash);
        step_res = '0;
        case (cmd)
            CMD_BOTH: keyer_paddles(dot, dash);
            CMD_DOT: keyer_paddles(dot, held_dash);
            CMD_DASH: keyer_paddles(held_dot, dash);
            CMD_DONE: keyer_advance();
            CMD_RESET: begin
                kst = ST_IDLE;
                {held_dot, held_dash, lat_dot, lat_dash, lat_sq} = '0;
            end
            default: ;
        endcase
        step_res.busy_res = (kst != ST_IDLE);
        step_res.state_code = kst;
        step_res.dot_latch_out = lat_dot;
        step_res.dash_latch_out = lat_dash;
        return step_res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic send_item(input logic [CMD_WIDTH-1:0] cmd, input logic dot,
                             input logic dash, input bit typed, input result_t want);
        result_t res;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_dot_pressed <= dot;
        s_dash_pressed <= dash;
        do @(posedge aclk); while (!s_ready);
        res = keyer_step(cmd, dot, dash);
        pending_tones.push_back(typed ? want : res);
        if (cmd > CMD_RESET) n_ignored++;
        else n_items++;
        if (res.tone_valid) n_tones++;
        if (kst == ST_IN_DOT_B || kst == ST_IN_DASH_B) n_squeeze++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_tones.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [TIME_WIDTH-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_MODE_B: mode_b_sel = data[0];
            REG_DOT_TIME: len_dot = data;
            REG_DASH_TIME: len_dash = data;
            REG_GAP_TIME: len_gap = data;
        endcase
        n_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tones.size() == 0) begin
                $display("%0t: result arrived with none expected", $time);
                errors++;
            end else begin
                want = pending_tones.pop_front();
                if (m_tone_valid !== want.tone_valid)
                    report_mismatch("tone_valid", m_tone_valid, want.tone_valid);
                if (m_key_closed !== want.key_closed)
                    report_mismatch("key_closed", m_key_closed, want.key_closed);
                if (m_tone_length !== want.tone_length)
                    report_mismatch("tone_length", m_tone_length, want.tone_length);
                if (m_busy_res !== want.busy_res)
                    report_mismatch("busy_res", m_busy_res, want.busy_res);
                if (m_state_code !== want.state_code)
                    report_mismatch("state_code", m_state_code, want.state_code);
                if (m_dot_latch_out !== want.dot_latch_out)
                    report_mismatch("dot_latch_out", m_dot_latch_out, want.dot_latch_out);
                if (m_dash_latch_out !== want.dash_latch_out)
                    report_mismatch("dash_latch_out", m_dash_latch_out,
                                    want.dash_latch_out);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("iambic_keyer_mode_a_b regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int r;
        int done_in_phase;
        logic [CMD_WIDTH-1:0] c;
        logic d, da;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_DONE;
        s_dot_pressed = 1'b0;
        s_dash_pressed = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODE_B;
        cfg_data = '0;
        kst = ST_IDLE;
        {held_dot, held_dash, lat_dot, lat_dash, lat_sq} = '0;
        mode_b_sel = 1'b0;
        len_dot = DOT_TIME_RESET;
        len_dash = DASH_TIME_RESET;
        len_gap = GAP_TIME_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                settle();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_item(script[i].cmd, script[i].dot, script[i].dash,
                          script[i].typed, script[i].want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            idle_on = (p != N_PHASES - 1);
            case (p)
                0: begin
                    write_reg(REG_MODE_B, TIME_WIDTH'(0));
                    write_reg(REG_DOT_TIME, TIME_WIDTH'(1));
                    write_reg(REG_DASH_TIME, TIME_WIDTH'(1));
                    write_reg(REG_GAP_TIME, '0);
                end
                1: begin
                    write_reg(REG_MODE_B, TIME_MAX);
                    write_reg(REG_DOT_TIME, TIME_MAX);
                    write_reg(REG_DASH_TIME, TIME_MAX);
                    write_reg(REG_GAP_TIME, TIME_MAX);
                end
                default: begin
                    write_reg(REG_MODE_B, TIME_WIDTH'($urandom));
                    write_reg(REG_DOT_TIME, TIME_WIDTH'($urandom_range(1, TIME_MAX)));
                    write_reg(REG_DASH_TIME, TIME_WIDTH'($urandom_range(1, TIME_MAX)));
                    write_reg(REG_GAP_TIME, TIME_WIDTH'($urandom_range(0, TIME_MAX)));
                end
            endcase
            done_in_phase = 0;
            while (done_in_phase < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                d = $urandom_range(0, 1);
                da = $urandom_range(0, 1);
                if (r < 45) c = CMD_DONE;
                else if (r < 65) c = CMD_BOTH;
                else if (r < 77) c = CMD_DOT;
                else if (r < 89) c = CMD_DASH;
                else if (r < 93) c = CMD_RESET;
                else c = CMD_WIDTH'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                send_item(c, d, da, 1'b0, '0);
                done_in_phase++;
            end
        end
        settle();
        repeat (5) @(posedge aclk);

        $display("Ran %0d keyer commands and %0d unused codes over %0d register writes.",
                 n_items, n_ignored, n_writes);
        $display("Predicted %0d tones; %0d steps entered a squeeze element.",
                 n_tones, n_squeeze);
        if (errors == 0) begin
            $display("iambic_keyer_mode_a_b regression: pass");
        end else begin
            $display("iambic_keyer_mode_a_b regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/iak_pkg.sv
design/iak_cfg_regs.sv
design/iak_step.sv
design/iambic_keyer_mode_a_b.sv
test/tb_iambic_keyer_mode_a_b.sv
